>>> design/mnp_pkg.sv
// ----------------------------------------------------------------------------
// mnp_pkg
// shared types and constants for the midi note priority cv block
// ----------------------------------------------------------------------------
package mnp_pkg;

	localparam int STACK_DEPTH_DEF = 8;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [7:0] NOTE_ON_STATUS = 8'h90;
	localparam logic [7:0] STATUS_MIN     = 8'h80;
	localparam logic [6:0] OFFSET_RESET   = 7'd21;

	// one command handed from the parser to the stack engine
	typedef struct packed {
		logic       push;   // 1: note on, 0: note off (velocity zero)
		logic [6:0] note;
	} cmd_t;

	// command plus its valid strobe
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	// parser position inside a message
	typedef enum logic [2:0] {
		POS_NONE = 3'b001,
		POS_NOTE = 3'b010,
		POS_VEL  = 3'b100
	} pos_t;

	// stack engine sequencer
	typedef enum logic [3:0] {
		BK_IDLE  = 4'b0001,
		BK_MATCH = 4'b0010,
		BK_APPLY = 4'b0100,
		BK_EMIT  = 4'b1000
	} bk_state_t;

endpackage

>>> design/mnp_front.sv
// ----------------------------------------------------------------------------
// mnp_front
// midi byte parser: tracks running status and issues note on / off commands
// ----------------------------------------------------------------------------
module mnp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	input  logic              q_full,
	output mnp_pkg::cmd_req_t cmd_push
);
	import mnp_pkg::*;

	pos_t       pos_q;
	logic       active_q;
	logic [6:0] pending_q;
	logic       accept;
	logic       is_status;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign is_status = rx_byte inside {[STATUS_MIN:8'hFF]};

	// a velocity byte under note-on status becomes a command
	always_comb begin
		cmd_push.valid    = accept && !is_status && (pos_q == POS_VEL) && active_q;
		cmd_push.cmd.push = (rx_byte != 8'd0);
		cmd_push.cmd.note = pending_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_NONE;
			active_q  <= 1'b0;
			pending_q <= '0;
		end else if (accept) begin
			if (is_status) begin
				active_q <= (rx_byte == NOTE_ON_STATUS);
				pos_q    <= POS_NOTE;
			end else begin
				case (pos_q)
					POS_NOTE: begin
						if (active_q) begin
							pending_q <= rx_byte[6:0];
						end
						pos_q <= POS_VEL;
					end
					POS_VEL:  pos_q <= POS_NOTE;
					default:  pos_q <= POS_NOTE;
				endcase
			end
		end
	end

endmodule

>>> design/mnp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mnp_cmd_fifo
// short command queue between the parser and the stack engine
// ----------------------------------------------------------------------------
module mnp_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  mnp_pkg::cmd_req_t wr,
	output logic              full,
	output mnp_pkg::cmd_req_t rd,
	input  logic              pop
);
	import mnp_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (cnt_q == CW'(QUEUE_DEPTH));
	assign rd.valid = (cnt_q != '0);
	assign rd.cmd   = mem_q[rd_ptr_q];
	assign do_wr    = wr.valid && !full;
	assign do_rd    = pop && rd.valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> design/mnp_stack.sv
// ----------------------------------------------------------------------------
// mnp_stack
// held-note stack engine: push / remove, then cv and gate result register
// ----------------------------------------------------------------------------
module mnp_stack #(
	parameter int STACK_DEPTH = mnp_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mnp_pkg::cmd_req_t cmd_in,
	output logic              cmd_pop,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [6:0]        note_offset,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        cv_value,
	output logic              gate
);
	import mnp_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);

	bk_state_t              state_q;
	cmd_t                   cmd_q;
	logic [6:0]             held_q [STACK_DEPTH];
	logic [CW-1:0]          count_q;
	logic [STACK_DEPTH-1:0] match_d;
	logic [STACK_DEPTH-1:0] match_q;
	logic [STACK_DEPTH-1:0] shift_rm;
	logic                   found;
	logic [6:0]             offset_q;
	logic                   out_valid_q;
	logic [7:0]             cv_q;
	logic                   gate_q;

	assign cfg_ready = 1'b1;
	assign cmd_pop   = (state_q == BK_IDLE);
	assign out_valid = out_valid_q;
	assign cv_value  = cv_q;
	assign gate      = gate_q;

	// compare every live slot against the note to remove
	always_comb begin
		for (int i = 0; i < STACK_DEPTH; i++) begin
			match_d[i] = (CW'(i) < count_q) && (held_q[i] == cmd_q.note);
		end
	end

	// slots at or above the deepest match move up by one
	assign found = |match_q;
	always_comb begin
		for (int i = 0; i < STACK_DEPTH; i++) begin
			shift_rm[i] = found && ((match_q >> (i + 1)) == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= note_offset;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE:  cmd_q   <= cmd_in.cmd;
			BK_MATCH: match_q <= match_d;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			cv_q        <= '0;
			gate_q      <= 1'b0;
			for (int i = 0; i < STACK_DEPTH; i++) begin
				held_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready && (state_q != BK_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (cmd_in.valid) begin
						state_q <= BK_MATCH;
					end
				end
				BK_MATCH: state_q <= BK_APPLY;
				BK_APPLY: begin
					if (cmd_q.push) begin
						held_q[0] <= cmd_q.note;
						for (int i = 1; i < STACK_DEPTH; i++) begin
							if (CW'(i) <= count_q) begin
								held_q[i] <= held_q[i-1];
							end
						end
						if (count_q != CW'(STACK_DEPTH)) begin
							count_q <= count_q + 1'b1;
						end
					end else begin
						for (int i = 0; i < STACK_DEPTH - 1; i++) begin
							if (shift_rm[i] && (CW'(i + 1) < count_q)) begin
								held_q[i] <= held_q[i+1];
							end
						end
						if (found) begin
							count_q <= count_q - 1'b1;
						end
					end
					state_q <= BK_EMIT;
				end
				BK_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						cv_q        <= {1'b0, held_q[0]} - {1'b0, offset_q};
						gate_q      <= (count_q != '0);
						state_q     <= BK_IDLE;
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

endmodule

>>> design/midi_note_priority_cv_top.sv
// path: a velocity byte under note-on status is written into the queue when it is
//   accepted, then taken by the stack engine; it waits longer while earlier commands are still in the
//   stack engine or the result register waits on out_ready
// flow: bytes are taken while the queue is not full; each note on / off goes through
//   pop, compare, stack update and result load in the stack engine, one at a time
// reset: arst_n clears parser, queue, stack and result register at once; offset is 21
// ----------------------------------------------------------------------------
// midi_note_priority_cv_top
// midi bytes in, last-note-priority cv value and gate out
// ----------------------------------------------------------------------------
module midi_note_priority_cv_top #(
	parameter int STACK_DEPTH = mnp_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// midi byte items
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	// result items
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cv_value,
	output logic       gate,
	// note offset register write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] note_offset
);
	import mnp_pkg::*;

	cmd_req_t q_wr;
	cmd_req_t q_rd;
	logic     q_full;
	logic     q_pop;

	// front: parses running status, latches the note, issues a command per velocity byte under note-on status
	mnp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.cmd_push (q_wr)
	);

	// queue lets the parser keep taking bytes while the stack engine is busy
	mnp_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.rd     (q_rd),
		.pop    (q_pop)
	);

	// back: stack update and registered cv / gate result
	mnp_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_in      (q_rd),
		.cmd_pop     (q_pop),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.note_offset (note_offset),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cv_value    (cv_value),
		.gate        (gate)
	);

endmodule

>>> design/mnp_checker.sv
// ----------------------------------------------------------------------------
// mnp_checker
// port-level checks on the midi note priority cv block
// ----------------------------------------------------------------------------
module mnp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] cv_value,
	input logic       gate,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cv_value) && $stable(gate))
		else $error("result changed while stalled");

	// a waiting input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(rx_byte))
		else $error("input item changed while stalled");

	// handshake outputs and a presented result are never unknown
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_ready, out_valid, cfg_ready}) &&
		(!out_valid || !$isunknown({cv_value, gate})))
		else $error("unknown value on outputs");

	// offset writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind midi_note_priority_cv_top mnp_checker u_mnp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.rx_byte   (rx_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.cv_value  (cv_value),
	.gate      (gate),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

>>> tb/tb_midi_note_priority_cv_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_note_priority_cv_top
// self-checking bench for the last-note-priority midi to cv converter:
// midi bytes go in through a queued driver, a predictor tracks the parser
// and the held-note stack, and a monitor checks every cv value and gate
// ----------------------------------------------------------------------------
module tb_midi_note_priority_cv_top;
	import mnp_pkg::*;

	localparam int STACK_DEPTH = STACK_DEPTH_DEF;
	localparam int CLK_PERIOD  = 8;
	// run limit, well above the slowest correct run
	localparam int RUN_LIMIT_NS = 2_000_000;
	// cycles to let a byte that gives no result pass through the block
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD_OFF = 300;

	// one result as the block should present it
	typedef struct packed {
		logic [7:0] cv;
		logic       gate;
	} cv_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] cv_value;
	logic       gate;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [6:0] note_offset = 7'd0;

	// bytes waiting for the driver, results waiting for the monitor
	logic [7:0] midi_byte_q [$];
	cv_result_t cv_result_q [$];
	int bytes_queued   = 0;
	int bytes_accepted = 0;
	int fail_cnt       = 0;

	// idling on or off for both sides, and long hold-off requests
	logic idle_en = 1'b1;
	int hold_off_req  = 0;
	int hold_off_done = 0;

	// predictor state
	pos_t       msg_pos = POS_NONE;
	logic       note_on_seen = 1'b0;
	logic [6:0] latched_note = 7'd0;
	logic [6:0] held_stack [STACK_DEPTH] = '{default: 7'd0};
	int         held_depth = 0;
	logic [6:0] offset_model = OFFSET_RESET;

	midi_note_priority_cv_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cv_value   (cv_value),
		.gate       (gate),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.note_offset(note_offset)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// idle cycles before the next item on either side
	function automatic int draw_gap();
		return idle_en ? $urandom_range(0, 4) : 0;
	endfunction

	// note on: newest note on top, oldest falls off the bottom when full
	function automatic void push_held_note(input logic [6:0] n);
		int top;
		top = (held_depth >= STACK_DEPTH) ? STACK_DEPTH - 1 : held_depth;
		for (int i = top; i >= 1; i--)
			held_stack[i] = held_stack[i - 1];
		held_stack[0] = n;
		if (held_depth < STACK_DEPTH)
			held_depth++;
	endfunction

	// note off: drop the deepest matching entry, nothing if not held
	function automatic void release_held_note(input logic [6:0] n);
		int   at;
		logic found;
		at    = 0;
		found = 1'b0;
		for (int k = held_depth - 1; k >= 0; k--) begin
			if (held_stack[k] == n) begin
				at    = k;
				found = 1'b1;
				break;
			end
		end
		if (found) begin
			for (int i = at; i + 1 < held_depth; i++)
				held_stack[i] = held_stack[i + 1];
			held_depth--;
		end
	endfunction

	// follow one accepted midi byte and queue the result it causes, if any
	function automatic void track_midi_byte(input logic [7:0] b);
		cv_result_t r;
		if (b >= STATUS_MIN) begin
			note_on_seen = (b == NOTE_ON_STATUS);
			msg_pos      = POS_NOTE;
		end else begin
			case (msg_pos)
				POS_NOTE: begin
					if (note_on_seen)
						latched_note = b[6:0];
					msg_pos = POS_VEL;
				end
				POS_VEL: begin
					if (note_on_seen) begin
						if (b == 8'd0)
							release_held_note(latched_note);
						else
							push_held_note(latched_note);
						// slot 0 keeps the last note even when the stack is empty
						r.cv   = {1'b0, held_stack[0]} - {1'b0, offset_model};
						r.gate = (held_depth > 0);
						cv_result_q.push_back(r);
					end
					// running status: the next data byte is a note again
					msg_pos = POS_NOTE;
				end
				default: msg_pos = POS_NOTE;
			endcase
		end
	endfunction

	// driver: one item per handshake, random gap after each accepted item
	int tx_gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			rx_byte     <= 8'h00;
			tx_gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				track_midi_byte(rx_byte);
				bytes_accepted++;
				tx_gap_left = draw_gap();
			end
			if (in_valid && !in_ready) begin
				// hold valid and payload until the item is taken
			end else if (tx_gap_left > 0) begin
				tx_gap_left--;
				in_valid <= 1'b0;
			end else if (midi_byte_q.size() > 0) begin
				in_valid <= 1'b1;
				rx_byte  <= midi_byte_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks results in order, stalls at random, long hold-off on request
	int rx_gap_left = 0;
	int hold_off_left = 0;
	always @(posedge clk or negedge arst_n) begin
		cv_result_t want;
		if (!arst_n) begin
			out_ready     <= 1'b0;
			rx_gap_left   = 0;
			hold_off_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cv_result_q.size() == 0) begin
					$error("cv_value/gate: unexpected result, cv_value %0d gate %0b",
						cv_value, gate);
					fail_cnt++;
				end else begin
					want = cv_result_q.pop_front();
					if (cv_value !== want.cv) begin
						$error("cv_value: expected %0d, actual %0d", want.cv, cv_value);
						fail_cnt++;
					end
					if (gate !== want.gate) begin
						$error("gate: expected %0b, actual %0b", want.gate, gate);
						fail_cnt++;
					end
				end
				rx_gap_left = draw_gap();
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				out_ready <= 1'b0;
			end else if (hold_off_req != hold_off_done) begin
				// long hold-off so the block backs up and stalls its input
				hold_off_done++;
				hold_off_left = LONG_HOLD_OFF;
				out_ready     <= 1'b0;
			end else if (rx_gap_left > 0) begin
				rx_gap_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		midi_byte_q.push_back(b);
		bytes_queued++;
	endtask

	// wait until every byte is taken and every result has come, then settle
	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || cv_result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// offset register write, only while the block is idle
	task automatic write_offset(input logic [6:0] v);
		@(posedge clk);
		cfg_valid   <= 1'b1;
		note_offset <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		offset_model = v;
	endtask

	// mostly note on / note off pairs under running status, some noise
	task automatic queue_random_traffic(input int n_bytes, input int push_pct);
		int         first;
		int         sel;
		logic [6:0] pool_base;
		logic [6:0] r7;
		logic [6:0] note;
		logic [6:0] vel;
		first     = bytes_queued;
		pool_base = 7'($urandom_range(0, 118));
		while (bytes_queued - first < n_bytes) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				queue_byte(NOTE_ON_STATUS);
			end else if (sel < 18) begin
				case ($urandom_range(0, 2))
					0: begin
						// any status byte, may turn note handling off
						r7 = 7'($urandom_range(0, 127));
						queue_byte({1'b1, r7});
					end
					1: begin
						// stray data byte shifts note / velocity pairing
						r7 = 7'($urandom_range(0, 127));
						queue_byte({1'b0, r7});
					end
					default: begin
						// foreign message, then back to note on
						r7 = 7'($urandom_range(0, 127));
						queue_byte({1'b1, r7});
						r7 = 7'($urandom_range(0, 127));
						queue_byte({1'b0, r7});
						r7 = 7'($urandom_range(0, 127));
						queue_byte({1'b0, r7});
						queue_byte(NOTE_ON_STATUS);
					end
				endcase
			end else begin
				// small note pool so the stack fills, duplicates and overflows
				if ($urandom_range(0, 3) != 0)
					note = pool_base + 7'($urandom_range(0, 9));
				else
					note = 7'($urandom_range(0, 127));
				vel = ($urandom_range(0, 99) < push_pct) ? 7'($urandom_range(1, 127)) : 7'd0;
				queue_byte({1'b0, note});
				queue_byte({1'b0, vel});
			end
		end
	endtask

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

	// stimulus sequence
	initial begin
		logic [6:0] r7;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, reset offset of 21
		// data before any status: advances the parser but note handling is off
		queue_byte(8'h00);
		queue_byte(8'h7F);
		// lowest note, top velocity: cv wraps below zero
		queue_byte(NOTE_ON_STATUS);
		queue_byte(8'h00);
		queue_byte(8'h7F);
		// running status, highest note, lowest nonzero velocity
		queue_byte(8'h7F);
		queue_byte(8'h01);
		// note off for a note that is not held
		queue_byte(8'h55);
		queue_byte(8'h00);
		// release both, cv holds the last note with gate low
		queue_byte(8'h7F);
		queue_byte(8'h00);
		queue_byte(8'h00);
		queue_byte(8'h00);
		// note off status and top status byte are ignored with their data
		queue_byte(8'h80);
		queue_byte(8'h40);
		queue_byte(8'h40);
		queue_byte(8'hFF);
		queue_byte(8'h3C);
		queue_byte(8'h40);
		// status in the middle of a message restarts it
		queue_byte(NOTE_ON_STATUS);
		queue_byte(8'h3C);
		queue_byte(NOTE_ON_STATUS);
		queue_byte(8'h3D);
		queue_byte(8'h50);
		wait_drained();

		// lowest offset
		write_offset(7'd0);
		queue_random_traffic(130, 60);
		wait_drained();

		// highest offset, receiver backs off while the sender keeps going
		write_offset(7'd127);
		hold_off_req <= hold_off_req + 1;
		queue_random_traffic(130, 55);
		wait_drained();

		// no idling on either side
		r7 = 7'($urandom_range(0, 127));
		write_offset(r7);
		idle_en <= 1'b0;
		queue_random_traffic(130, 65);
		wait_drained();

		idle_en <= 1'b1;
		r7 = 7'($urandom_range(0, 127));
		write_offset(r7);
		queue_random_traffic(130, 50);
		wait_drained();

		write_offset(OFFSET_RESET);
		queue_random_traffic(130, 55);
		wait_drained();

		if (fail_cnt == 0 && cv_result_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
